@@ hdl/rcots_pkg.sv @@
// shared types and constants for the oscillator trim search
`default_nettype none

package rcots_pkg;

  // configuration register indexes
  localparam logic CFG_TARGET_COUNT = 1'b0;
  localparam logic CFG_START_TRIM   = 1'b1;

  localparam int unsigned CFG_INDEX_BITS = 1;

  // reset values of the configuration registers
  localparam int unsigned TARGET_COUNT_RESET = 1808;
  localparam int unsigned START_TRIM_RESET   = 64;

  // direction and completion flags of one search
  typedef struct packed {
    logic was_above;
    logic was_below;
    logic finished;
  } search_flags_t;

endpackage

`default_nettype wire

@@ hdl/rcots_step.sv @@
// next-state logic for one trim search step
`default_nettype none

module rcots_step #(
  parameter int unsigned TRIM_BITS  = 7,
  parameter int unsigned COUNT_BITS = 20
) (
  input  wire logic [COUNT_BITS-1:0] measured_count,
  input  wire logic                  begin_run,
  input  wire logic [COUNT_BITS-1:0] target_count,
  input  wire logic [TRIM_BITS-1:0]  start_trim,
  input  wire logic [TRIM_BITS-1:0]  trim_now,
  input  wire logic [TRIM_BITS-1:0]  trim_before,
  input  wire logic [COUNT_BITS-1:0] count_before,
  input  wire rcots_pkg::search_flags_t flags,
  output logic [TRIM_BITS-1:0]       trim_now_next,
  output logic [TRIM_BITS-1:0]       trim_before_next,
  output logic [COUNT_BITS-1:0]      count_before_next,
  output rcots_pkg::search_flags_t   flags_next,
  output logic                       write_next
);

  localparam logic [TRIM_BITS-1:0]  TRIM_MAX  = {TRIM_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  logic [TRIM_BITS-1:0]     trim_cur;
  logic [TRIM_BITS-1:0]     trim_prev;
  logic [COUNT_BITS-1:0]    count_prev;
  rcots_pkg::search_flags_t flags_cur;
  logic                     below;
  logic                     above;
  logic [COUNT_BITS-1:0]    err_now;
  logic [COUNT_BITS-1:0]    err_prev;

  // begin_run restarts the search before the count is used
  always_comb begin
    if (begin_run) begin
      trim_cur   = start_trim;
      trim_prev  = '0;
      count_prev = '0;
      flags_cur  = '0;
    end else begin
      trim_cur   = trim_now;
      trim_prev  = trim_before;
      count_prev = count_before;
      flags_cur  = flags;
    end
  end

  assign below    = measured_count < target_count;
  assign above    = measured_count > target_count;
  assign err_now  = below ? (target_count - measured_count) : (measured_count - target_count);
  assign err_prev = (count_prev > target_count) ? (count_prev - target_count)
                                                : (target_count - count_prev);

  always_comb begin
    trim_now_next     = trim_cur;
    trim_before_next  = trim_prev;
    count_before_next = count_prev;
    flags_next        = flags_cur;
    write_next        = 1'b0;
    if (!flags_cur.finished) begin
      if (below || above) begin
        write_next = 1'b1;
        // crossed the target: keep the trim with the smaller error, the present one on a tie
        if ((below && flags_cur.was_above) || (above && flags_cur.was_below)) begin
          if (err_now > err_prev) begin
            trim_now_next = trim_prev;
          end
          flags_next.finished = 1'b1;
        end else if (err_now == COUNT_ONE) begin
          flags_next.finished = 1'b1;
        end else begin
          trim_before_next  = trim_cur;
          count_before_next = measured_count;
          if (below) begin
            flags_next.was_below = 1'b1;
            if (trim_cur != TRIM_MAX) begin
              trim_now_next = trim_cur + TRIM_BITS'(1);
            end
          end else begin
            flags_next.was_above = 1'b1;
            if (trim_cur != '0) begin
              trim_now_next = trim_cur - TRIM_BITS'(1);
            end
          end
        end
      end else begin
        flags_next.finished = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/rc_oscillator_trim_search_unit.sv @@
// top level of the oscillator trim step search
`default_nettype none

// Each request carries one measured reference count; the unit steps the trim one code
// toward target_count and returns one result per request. A request is registered on
// acceptance and its result is registered from the input register once the output can
// advance; a new request is taken every cycle while in_stall is low. The search state is
// updated in the same cycle the result register loads. A stalled output holds the input
// register, and in_stall rises only when both registers are full. Configuration writes
// take effect immediately and are meant for idle periods.
module rc_oscillator_trim_search_unit #(
  parameter int unsigned TRIM_BITS  = 7,
  parameter int unsigned COUNT_BITS = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [rcots_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [COUNT_BITS-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COUNT_BITS-1:0] measured_count,
  input  wire logic                  begin_run,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [TRIM_BITS-1:0]       trim_value,
  output logic                       write_trim,
  output logic                       done_res
);

  localparam logic [COUNT_BITS-1:0] TARGET_RESET = COUNT_BITS'(rcots_pkg::TARGET_COUNT_RESET);
  localparam logic [TRIM_BITS-1:0]  START_RESET  = TRIM_BITS'(rcots_pkg::START_TRIM_RESET);

  logic [COUNT_BITS-1:0]    target_count;
  logic [TRIM_BITS-1:0]     start_trim;

  logic                     in_hold;
  logic [COUNT_BITS-1:0]    in_count;
  logic                     in_begin;

  logic [TRIM_BITS-1:0]     trim_now;
  logic [TRIM_BITS-1:0]     trim_before;
  logic [COUNT_BITS-1:0]    count_before;
  rcots_pkg::search_flags_t flags;

  logic [TRIM_BITS-1:0]     trim_now_next;
  logic [TRIM_BITS-1:0]     trim_before_next;
  logic [COUNT_BITS-1:0]    count_before_next;
  rcots_pkg::search_flags_t flags_next;
  logic                     write_next;

  logic                     advance;
  logic                     in_take;
  logic                     load;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_hold && !advance;
  assign in_take  = in_valid && !in_stall;
  assign load     = in_hold && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_count <= TARGET_RESET;
      start_trim   <= START_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rcots_pkg::CFG_TARGET_COUNT: target_count <= cfg_data;
        rcots_pkg::CFG_START_TRIM:   start_trim   <= cfg_data[TRIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_hold <= 1'b0;
    end else if (in_take) begin
      in_hold <= 1'b1;
    end else if (advance) begin
      in_hold <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_count <= measured_count;
      in_begin <= begin_run;
    end
  end

  rcots_step #(
    .TRIM_BITS  (TRIM_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .measured_count    (in_count),
    .begin_run         (in_begin),
    .target_count      (target_count),
    .start_trim        (start_trim),
    .trim_now          (trim_now),
    .trim_before       (trim_before),
    .count_before      (count_before),
    .flags             (flags),
    .trim_now_next     (trim_now_next),
    .trim_before_next  (trim_before_next),
    .count_before_next (count_before_next),
    .flags_next        (flags_next),
    .write_next        (write_next)
  );

  // search state moves with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      trim_now     <= START_RESET;
      trim_before  <= '0;
      count_before <= '0;
      flags        <= '0;
    end else if (load) begin
      trim_now     <= trim_now_next;
      trim_before  <= trim_before_next;
      count_before <= count_before_next;
      flags        <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      trim_value <= trim_now_next;
      write_trim <= write_next;
      done_res   <= flags_next.finished;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result register can drain");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (trim_value == trim_now && done_res == flags.finished))
    else $error("result register disagrees with search state");

  a_no_write_after_done: assert property (@(posedge clk) disable iff (rst)
    (load && flags.finished && !in_begin) |=> (!write_trim && done_res))
    else $error("trim written after search finished");

endmodule

`default_nettype wire

@@ tb/sv/rc_oscillator_trim_search_unit_tb.sv @@
// testbench for the oscillator trim step search unit
`timescale 1ns / 1ps

module rc_oscillator_trim_search_unit_tb;

  localparam int TRIM_W = 7;
  localparam int COUNT_W = 20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TRIM_W-1:0] TRIM_MAX = '1;
  localparam int RANDOM_ITEMS = 1550;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int PLAN_ROWS = 31;

  typedef struct packed {
    logic [TRIM_W-1:0] trim;
    logic write;
    logic done;
  } trim_result_t;

  typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    logic [rcots_pkg::CFG_INDEX_BITS-1:0] index;
    logic [COUNT_W-1:0] value;
    logic start;
    logic typed;
    logic [TRIM_W-1:0] trim;
    logic write;
    logic done;
  } plan_row_t;

  // value is the measured count for a request and the write data for a register write
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    // exact match straight out of reset, then an ignored count
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd1808,    1'b0, 1'b1, 7'd64,  1'b0, 1'b1},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd0,       1'b0, 1'b1, 7'd64,  1'b0, 1'b1},
    // far above, step down twice, cross with a small error
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'hFFFFF,   1'b1, 1'b1, 7'd63,  1'b1, 1'b0},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'hFFFFF,   1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd1807,    1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    // off by one on either side
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd1809,    1'b1, 1'b1, 7'd64,  1'b1, 1'b1},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd1807,    1'b1, 1'b1, 7'd64,  1'b1, 1'b1},
    // below twice, then overshoot so the previous trim wins
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd0,       1'b1, 1'b0, 7'd0,   1'b0, 1'b0},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd1000,    1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd5000,    1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    // above three times, cross with an equal error so the present trim stays
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd2000,    1'b1, 1'b0, 7'd0,   1'b0, 1'b0},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd1900,    1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd1850,    1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd1766,    1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    // saturation at the top trim
    '{ROW_WRITE,   rcots_pkg::CFG_START_TRIM,   20'd127,     1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd0,       1'b1, 1'b1, 7'd127, 1'b1, 1'b0},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd0,       1'b0, 1'b1, 7'd127, 1'b1, 1'b0},
    // saturation at trim zero, upper data bits must be dropped
    '{ROW_WRITE,   rcots_pkg::CFG_START_TRIM,   20'hFFF80,   1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'hFFFFF,   1'b1, 1'b1, 7'd0,   1'b1, 1'b0},
    // target at both ends of its range
    '{ROW_WRITE,   rcots_pkg::CFG_TARGET_COUNT, 20'd0,       1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd0,       1'b1, 1'b1, 7'd0,   1'b0, 1'b1},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd1,       1'b1, 1'b1, 7'd0,   1'b1, 1'b1},
    '{ROW_WRITE,   rcots_pkg::CFG_TARGET_COUNT, 20'hFFFFF,   1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'hFFFFF,   1'b1, 1'b1, 7'd0,   1'b0, 1'b1},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'hFFFFE,   1'b1, 1'b1, 7'd0,   1'b1, 1'b1},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd0,       1'b1, 1'b0, 7'd0,   1'b0, 1'b0},
    // target moved in the middle of a search
    '{ROW_WRITE,   rcots_pkg::CFG_TARGET_COUNT, 20'd100,     1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd50,      1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{ROW_REQUEST, rcots_pkg::CFG_TARGET_COUNT, 20'd150,     1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{ROW_WRITE,   rcots_pkg::CFG_TARGET_COUNT, 20'd1808,    1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{ROW_WRITE,   rcots_pkg::CFG_START_TRIM,   20'd64,      1'b0, 1'b0, 7'd0,   1'b0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [rcots_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [COUNT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [COUNT_W-1:0] measured_count = '0;
  logic begin_run = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TRIM_W-1:0] trim_value;
  logic write_trim;
  logic done_res;

  // predicted search state and registers
  logic [COUNT_W-1:0] target_reg;
  logic [TRIM_W-1:0] start_reg;
  logic [TRIM_W-1:0] trim_cur;
  logic [TRIM_W-1:0] trim_prev;
  logic [COUNT_W-1:0] count_prev;
  rcots_pkg::search_flags_t flags;

  trim_result_t trim_expect_q[$];
  logic quiet_mode = 1'b0;
  int stall_left = 0;
  int mismatches = 0;
  int n_requests = 0;
  int n_processed = 0;
  int n_checked = 0;
  int n_runs = 0;
  int n_cfg_writes = 0;

  rc_oscillator_trim_search_unit #(
    .TRIM_BITS(TRIM_W),
    .COUNT_BITS(COUNT_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .measured_count(measured_count),
    .begin_run(begin_run),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .trim_value(trim_value),
    .write_trim(write_trim),
    .done_res(done_res)
  );

  always #10 clk = ~clk;

  // mostly no gap, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [COUNT_W-1:0] count_error(input logic [COUNT_W-1:0] a,
                                                     input logic [COUNT_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic restart_search();
    trim_cur = start_reg;
    trim_prev = '0;
    count_prev = '0;
    flags = '0;
  endtask

  task automatic step_trim_search(input logic [COUNT_W-1:0] m, input logic start,
                                  output trim_result_t res);
    logic [COUNT_W-1:0] err_now;
    res = '0;
    if (start) restart_search();
    if (!flags.finished) begin
      n_processed++;
      if (m < target_reg) begin
        err_now = target_reg - m;
        if (flags.was_above) begin
          // crossed from above: fall back only if the last trim was strictly closer
          if (err_now > count_error(count_prev, target_reg)) trim_cur = trim_prev;
          flags.finished = 1'b1;
        end else if (err_now == 1) begin
          flags.finished = 1'b1;
        end else begin
          trim_prev = trim_cur;
          if (trim_cur != TRIM_MAX) trim_cur = trim_cur + 1'b1;
          flags.was_below = 1'b1;
          count_prev = m;
        end
        res.write = 1'b1;
      end else if (m > target_reg) begin
        err_now = m - target_reg;
        if (flags.was_below) begin
          if (err_now > count_error(count_prev, target_reg)) trim_cur = trim_prev;
          flags.finished = 1'b1;
        end else if (err_now == 1) begin
          flags.finished = 1'b1;
        end else begin
          trim_prev = trim_cur;
          if (trim_cur != '0) trim_cur = trim_cur - 1'b1;
          flags.was_above = 1'b1;
          count_prev = m;
        end
        res.write = 1'b1;
      end else begin
        flags.finished = 1'b1;
      end
    end
    res.trim = trim_cur;
    res.done = flags.finished;
  endtask

  task automatic send_measurement(input logic [COUNT_W-1:0] m, input logic start,
                                  input logic use_typed, input trim_result_t typed);
    trim_result_t res;
    in_valid <= 1'b1;
    measured_count <= m;
    begin_run <= start;
    do @(posedge clk); while (in_stall);
    step_trim_search(m, start, res);
    trim_expect_q.push_back(use_typed ? typed : res);
    n_requests++;
  endtask

  task automatic pause_sender();
    int gap;
    gap = quiet_mode ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      measured_count <= COUNT_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain every outstanding result plus the pipeline depth
  task automatic settle();
    in_valid <= 1'b0;
    while (trim_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rcots_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [COUNT_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == rcots_pkg::CFG_TARGET_COUNT) target_reg = data;
    else start_reg = data[TRIM_W-1:0];
    n_cfg_writes++;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic retune();
    logic [COUNT_W-1:0] tgt;
    logic [TRIM_W-1:0] st;
    int pick;
    settle();
    pick = $urandom_range(0, 9);
    tgt = (pick == 0) ? '0 : (pick == 1) ? COUNT_MAX :
          (pick < 5) ? COUNT_W'($urandom_range(0, 4000)) : COUNT_W'($urandom);
    pick = $urandom_range(0, 9);
    st = (pick == 0) ? '0 : (pick == 1) ? TRIM_MAX : TRIM_W'($urandom);
    if ($urandom_range(0, 2) != 0) write_reg(rcots_pkg::CFG_TARGET_COUNT, tgt);
    if ($urandom_range(0, 2) != 0) begin
      write_reg(rcots_pkg::CFG_START_TRIM, {(COUNT_W-TRIM_W)'($urandom), st});
    end
  endtask

  // counts follow a linear oscillator around a hidden ideal trim, with jitter and occasional random counts
  task automatic calibration_run();
    int ideal;
    int slope;
    int jitter;
    int limit;
    int steps;
    longint level;
    logic [COUNT_W-1:0] m;
    logic start;
    ideal = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 127)) :
            int'(start_reg) + int'($urandom_range(0, 30)) - 15;
    slope = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 4)) :
            int'($urandom_range(5, 400));
    limit = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 5)) : 48;
    quiet_mode = ($urandom_range(0, 5) == 0);
    steps = 0;
    n_runs++;
    do begin
      if ($urandom_range(0, 14) == 0) begin
        m = COUNT_W'($urandom);
        start = 1'($urandom_range(0, 1));
      end else begin
        jitter = int'($urandom_range(0, slope)) - slope / 2;
        level = longint'(target_reg) + longint'(slope) * (longint'(trim_cur) - ideal) + jitter;
        m = (level < 0) ? '0 : (level > longint'(COUNT_MAX)) ? COUNT_MAX : level[COUNT_W-1:0];
        start = (steps == 0);
      end
      send_measurement(m, start, 1'b0, '0);
      pause_sender();
      steps++;
    end while (!flags.finished && steps < limit);
    if ($urandom_range(0, 3) == 0) begin
      send_measurement(COUNT_W'($urandom), 1'b0, 1'b0, '0);
      pause_sender();
    end
  endtask

  // result side: check against the oldest expectation, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin : check_result
      trim_result_t want;
      n_checked++;
      if (trim_expect_q.size() == 0) begin
        $error("result with no request outstanding: trim_value %0d", trim_value);
        mismatches++;
      end else begin
        want = trim_expect_q.pop_front();
        if (trim_value !== want.trim) begin
          $error("trim_value: expected %0d, got %0d", want.trim, trim_value);
          mismatches++;
        end
        if (write_trim !== want.write) begin
          $error("write_trim: expected %0d, got %0d", want.write, write_trim);
          mismatches++;
        end
        if (done_res !== want.done) begin
          $error("done_res: expected %0d, got %0d", want.done, done_res);
          mismatches++;
        end
      end
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0 && !quiet_mode) stall_left = idle_len();
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no request or result moved for %0d cycles", WATCHDOG_CYCLES);
    $display("[rc_oscillator_trim_search_unit] ERROR");
    $finish;
  end

  initial begin
    plan_row_t row;
    target_reg = COUNT_W'(rcots_pkg::TARGET_COUNT_RESET);
    start_reg = TRIM_W'(rcots_pkg::START_TRIM_RESET);
    restart_search();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_PLAN[i]) begin
      row = DIRECTED_PLAN[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_reg(row.index, row.value);
      end else begin
        send_measurement(row.value, row.start, row.typed, '{row.trim, row.write, row.done});
        pause_sender();
      end
    end

    while (n_requests < RANDOM_ITEMS) begin
      if ($urandom_range(0, 11) == 0) retune();
      calibration_run();
    end
    settle();

    $display("ran %0d requests (%0d stepped the search) in %0d calibration runs, %0d reg writes",
             n_requests, n_processed, n_runs, n_cfg_writes);
    $display("checked %0d results, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0) begin
      $display("[rc_oscillator_trim_search_unit] OK");
    end else begin
      $display("[rc_oscillator_trim_search_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ rc_oscillator_trim_search_unit.f @@
hdl/rcots_pkg.sv
hdl/rcots_step.sv
hdl/rc_oscillator_trim_search_unit.sv
tb/sv/rc_oscillator_trim_search_unit_tb.sv
